// ----- sv/dmws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dmws_pkg;

  // Default build parameters
  localparam int MAX_MOTIF_LENGTH_DEF = 32;
  localparam int WEIGHT_BITS_DEF      = 16;

  // Motif length after reset
  localparam int DEFAULT_MOTIF_LENGTH = 8;

  // Port widths fixed by the item format
  localparam int SCORE_W   = 21;
  localparam int CFG_W     = 6;
  localparam int POS_W     = 5;
  localparam int WVALUE_W  = 16;
  localparam int CHAR_W    = 8;

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII letters of the four nucleotides
  localparam logic [CHAR_W-1:0] CHR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHR_T_LO = 8'h74;

  // Nucleotide codes; complement is the bitwise inverse
  localparam logic [1:0] NUC_A = 2'd0;
  localparam logic [1:0] NUC_C = 2'd1;
  localparam logic [1:0] NUC_G = 2'd2;
  localparam logic [1:0] NUC_T = 2'd3;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_BASE = 1'b1
  } func_e;

  typedef struct packed {
    logic       bad;
    logic [1:0] code;
  } base_dec_t;

  // One classified item as it sits in the queue
  typedef struct packed {
    func_e               func;
    logic [POS_W-1:0]    pos;
    logic [1:0]          wbase;
    logic [WVALUE_W-1:0] wvalue;
    logic [1:0]          code;
    logic                bad;
  } q_item_t;

  // Flags that travel alongside the adder tree
  typedef struct packed {
    logic vld;
    logic rdy;
    logic bad;
  } flg_t;

  // Map an ASCII letter to a nucleotide code or flag it
  function automatic base_dec_t decode_base(input logic [CHAR_W-1:0] ch);
    base_dec_t r;
    r.bad  = 1'b0;
    r.code = NUC_A;
    unique case (ch) inside
      CHR_A_UP, CHR_A_LO: r.code = NUC_A;
      CHR_C_UP, CHR_C_LO: r.code = NUC_C;
      CHR_G_UP, CHR_G_LO: r.code = NUC_G;
      CHR_T_UP, CHR_T_LO: r.code = NUC_T;
      default:            r.bad  = 1'b1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dna_motif_window_scorer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o   func, weight_position, weight_base,
//                                         weight_value, base_code
// out      out  out_valid_o / out_ready_i forward_score, reverse_score,
//                                         window_ready, bad_base
// cfg      in   cfg_valid_i / cfg_ready_o cfg_data_i (motif_length)
//
// One item per clock while the output beat is not held; a base beat goes from queue pop
// into the leaf registers, through the four-way adder tree levels, then into the
// output register.
// Weight loads take one slot and give no result.
// Reset clears all weights, the window and the run count; motif length returns to 8 (capped at MAX_MOTIF_LENGTH).
// A held output beat stalls the back pipeline; the four-entry queue keeps
// in_ready_o high until it fills. cfg_ready_o is always high.

module dna_motif_window_scorer #(
  parameter int MAX_MOTIF_LENGTH = dmws_pkg::MAX_MOTIF_LENGTH_DEF,
  parameter int WEIGHT_BITS      = dmws_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [0:0]                    func_i,
  input  wire logic [dmws_pkg::POS_W-1:0]    weight_position_i,
  input  wire logic [1:0]                    weight_base_i,
  input  wire logic [dmws_pkg::WVALUE_W-1:0] weight_value_i,
  input  wire logic [dmws_pkg::CHAR_W-1:0]   base_code_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dmws_pkg::SCORE_W-1:0]       forward_score_o,
  output logic [dmws_pkg::SCORE_W-1:0]       reverse_score_o,
  output logic                               window_ready_o,
  output logic                               bad_base_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dmws_pkg::CFG_W-1:0]    cfg_data_i
);

  dmws_pkg::q_item_t front_item, back_item;
  logic              back_valid, back_pop;

  // Classify incoming beats
  dmws_front u_front (
    .func_i            (func_i),
    .weight_position_i (weight_position_i),
    .weight_base_i     (weight_base_i),
    .weight_value_i    (weight_value_i),
    .base_code_i       (base_code_i),
    .item_o            (front_item)
  );

  // Decouple front from back
  dmws_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_i        (back_pop),
    .pop_item_o   (back_item)
  );

  // Window, weights and scoring tree
  dmws_back #(
    .MAX_MOTIF_LENGTH (MAX_MOTIF_LENGTH),
    .WEIGHT_BITS      (WEIGHT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (back_valid),
    .item_i          (back_item),
    .pop_o           (back_pop),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .forward_score_o (forward_score_o),
    .reverse_score_o (reverse_score_o),
    .window_ready_o  (window_ready_o),
    .bad_base_o      (bad_base_o)
  );

endmodule

`default_nettype wire

// ----- sv/dmws_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmws_front (
  input  wire logic [0:0]                    func_i,
  input  wire logic [dmws_pkg::POS_W-1:0]    weight_position_i,
  input  wire logic [1:0]                    weight_base_i,
  input  wire logic [dmws_pkg::WVALUE_W-1:0] weight_value_i,
  input  wire logic [dmws_pkg::CHAR_W-1:0]   base_code_i,
  output dmws_pkg::q_item_t                  item_o
);

  dmws_pkg::base_dec_t dec;

  // Classify the letter once, before it is queued
  always_comb begin
    dec = dmws_pkg::decode_base(base_code_i);
  end

  // Pack the beat for the queue
  always_comb begin
    item_o.func   = dmws_pkg::func_e'(func_i);
    item_o.pos    = weight_position_i;
    item_o.wbase  = weight_base_i;
    item_o.wvalue = weight_value_i;
    item_o.code   = dec.code;
    item_o.bad    = dec.bad;
  end

endmodule

`default_nettype wire

// ----- sv/dmws_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmws_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  input  wire dmws_pkg::q_item_t push_item_i,
  output logic             pop_valid_o,
  input  wire logic        pop_i,
  output dmws_pkg::q_item_t pop_item_o
);

  dmws_pkg::q_item_t               mem_q [dmws_pkg::QUEUE_DEPTH];
  logic [dmws_pkg::QPTR_W-1:0]     wr_q, wr_d;
  logic [dmws_pkg::QPTR_W-1:0]     rd_q, rd_d;
  logic [dmws_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != dmws_pkg::QCNT_W'(dmws_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dmws_pkg::QCNT_W'(dmws_pkg::QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != dmws_pkg::QCNT_W'(dmws_pkg::QUEUE_DEPTH)) |->
      (dmws_pkg::QPTR_W'(cnt_q) == dmws_pkg::QPTR_W'(wr_q - rd_q)))
    else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

// ----- sv/dmws_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmws_back #(
  parameter int MAX_MOTIF_LENGTH = dmws_pkg::MAX_MOTIF_LENGTH_DEF,
  parameter int WEIGHT_BITS      = dmws_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         item_valid_i,
  input  wire dmws_pkg::q_item_t            item_i,
  output logic                              pop_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [dmws_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [dmws_pkg::SCORE_W-1:0]      forward_score_o,
  output logic [dmws_pkg::SCORE_W-1:0]      reverse_score_o,
  output logic                              window_ready_o,
  output logic                              bad_base_o
);

  localparam int PIDXW   = (MAX_MOTIF_LENGTH > 1) ? $clog2(MAX_MOTIF_LENGTH) : 1;
  localparam int CNTW    = $clog2(MAX_MOTIF_LENGTH + 1);
  localparam int LVL     = ($clog2(MAX_MOTIF_LENGTH) + 1) / 2;
  localparam int NLEAF   = 1 << (2 * LVL);
  localparam int NINT    = (NLEAF - 1) / 3;
  localparam int NNODE   = NINT + NLEAF;
  localparam int SUMW    = WEIGHT_BITS + 2 * LVL;
  localparam int EXTW    = (SUMW > dmws_pkg::SCORE_W) ? SUMW : dmws_pkg::SCORE_W;
  localparam int RST_LEN = (dmws_pkg::DEFAULT_MOTIF_LENGTH > MAX_MOTIF_LENGTH) ?
                           MAX_MOTIF_LENGTH : dmws_pkg::DEFAULT_MOTIF_LENGTH;

  // Weight cells: one row of four weights per motif position
  logic [3:0][WEIGHT_BITS-1:0] wt_q [MAX_MOTIF_LENGTH];
  logic [1:0]                  win_q [MAX_MOTIF_LENGTH];
  logic [1:0]                  win_new [MAX_MOTIF_LENGTH];
  logic [CNTW-1:0]             run_q, run_d, run_new;
  logic [CNTW-1:0]             len_q, len_d;

  logic [WEIGHT_BITS-1:0]      fwd_term [NLEAF];
  logic [WEIGHT_BITS-1:0]      rev_term [NLEAF];
  logic [SUMW-1:0]             fwd_q [NNODE];
  logic [SUMW-1:0]             fwd_d [NNODE];
  logic [SUMW-1:0]             rev_q [NNODE];
  logic [SUMW-1:0]             rev_d [NNODE];
  dmws_pkg::flg_t              flg_q [LVL+1];
  dmws_pkg::flg_t              flg_in;

  logic                        out_vld_q;
  logic [dmws_pkg::SCORE_W-1:0] fwd_out_q, rev_out_q;
  logic                        rdy_out_q, bad_out_q;
  logic [EXTW-1:0]             fwd_ext, rev_ext;

  logic                        adv, pop, is_base, base_clean, win_ok, score_en, load_we;
  logic [31:0]                 pos_ext, wv_ext;
  logic [PIDXW-1:0]            widx;

  // Whole pipeline moves unless the output beat is held
  assign adv     = !out_vld_q || out_ready_i;
  assign pop     = adv && item_valid_i;
  assign pop_o   = pop;
  assign is_base = (item_i.func == dmws_pkg::FUNC_BASE);

  assign base_clean = pop && is_base && !item_i.bad;
  assign pos_ext    = 32'(item_i.pos);
  assign wv_ext     = 32'(item_i.wvalue);
  assign widx       = pos_ext[PIDXW-1:0];
  assign load_we    = pop && !is_base && (pos_ext < 32'(MAX_MOTIF_LENGTH));

  // Clamp the written motif length into 1..MAX
  assign cfg_ready_o = 1'b1;
  always_comb begin
    if (cfg_data_i == '0) begin
      len_d = CNTW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_MOTIF_LENGTH)) begin
      len_d = CNTW'(MAX_MOTIF_LENGTH);
    end else begin
      len_d = CNTW'(cfg_data_i);
    end
  end

  // Shift the new base into the window
  always_comb begin
    win_new[0] = item_i.code;
    for (int a = 1; a < MAX_MOTIF_LENGTH; a++) begin
      win_new[a] = win_q[a-1];
    end
  end

  // Count clean bases, saturating; a bad base restarts the run
  always_comb begin
    run_new = (run_q < CNTW'(MAX_MOTIF_LENGTH)) ? run_q + 1'b1 : run_q;
    run_d   = run_q;
    if (pop && is_base) begin
      run_d = item_i.bad ? '0 : run_new;
    end
  end

  assign win_ok   = (run_new >= len_q);
  assign score_en = base_clean && win_ok;

  // Select one weight per position for each strand
  always_comb begin
    int fi;
    for (int i = 0; i < NLEAF; i++) begin
      fwd_term[i] = '0;
      rev_term[i] = '0;
    end
    for (int p = 0; p < MAX_MOTIF_LENGTH; p++) begin
      fi = int'(len_q) - 1 - p;
      if (score_en && (p < int'(len_q))) begin
        fwd_term[p] = wt_q[p][win_new[fi[PIDXW-1:0]]];
        rev_term[p] = wt_q[p][~win_new[p]];
      end
    end
  end

  // Four-way adder tree, leaves at the bottom of the heap
  always_comb begin
    for (int i = 0; i < NINT; i++) begin
      fwd_d[i] = fwd_q[4*i+1] + fwd_q[4*i+2] + fwd_q[4*i+3] + fwd_q[4*i+4];
      rev_d[i] = rev_q[4*i+1] + rev_q[4*i+2] + rev_q[4*i+3] + rev_q[4*i+4];
    end
    for (int i = 0; i < NLEAF; i++) begin
      fwd_d[NINT+i] = SUMW'(fwd_term[i]);
      rev_d[NINT+i] = SUMW'(rev_term[i]);
    end
  end

  always_comb begin
    flg_in.vld = pop && is_base;
    flg_in.rdy = score_en;
    flg_in.bad = is_base && item_i.bad;
  end

  assign fwd_ext = EXTW'(fwd_q[0]);
  assign rev_ext = EXTW'(rev_q[0]);

  // Config, window, run count and weight cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= CNTW'(RST_LEN);
      run_q <= '0;
      for (int p = 0; p < MAX_MOTIF_LENGTH; p++) begin
        win_q[p] <= '0;
        wt_q[p]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        len_q <= len_d;
      end
      run_q <= run_d;
      if (base_clean) begin
        win_q <= win_new;
      end
      if (load_we) begin
        wt_q[widx][item_i.wbase] <= wv_ext[WEIGHT_BITS-1:0];
      end
    end
  end

  // Tree payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
    end
  end

  // Flags ride along with the tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LVL; k++) begin
        flg_q[k] <= '0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      flg_q[0] <= flg_in;
      for (int k = 1; k <= LVL; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
      out_vld_q <= flg_q[LVL].vld;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_out_q <= fwd_ext[dmws_pkg::SCORE_W-1:0];
      rev_out_q <= rev_ext[dmws_pkg::SCORE_W-1:0];
      rdy_out_q <= flg_q[LVL].rdy;
      bad_out_q <= flg_q[LVL].bad;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign forward_score_o = fwd_out_q;
  assign reverse_score_o = rev_out_q;
  assign window_ready_o  = rdy_out_q;
  assign bad_base_o      = bad_out_q;

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && bad_out_q) |->
      (!rdy_out_q && (fwd_out_q == '0) && (rev_out_q == '0)))
    else $error("flagged base carries a score");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= CNTW'(MAX_MOTIF_LENGTH))
    else $error("clean run count above window depth");

  a_stall_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |-> !pop_o)
    else $error("queue popped while output is held");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) && (len_q <= CNTW'(MAX_MOTIF_LENGTH)))
    else $error("motif length outside window depth");

endmodule

`default_nettype wire
